FILE: rtl/sod_pkg.sv
// ----------------------------------------------------------------------------
// sod_pkg
// Shared types and constants of the sprite outline dilation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sod_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BORDER = 2'd2;
    localparam logic [1:0] CFG_COLOR  = 2'd3;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Job codes passed from front to back
    localparam logic [1:0] OP_WRITE = 2'd0;  // store one source pixel
    localparam logic [1:0] OP_QUERY = 2'd1;  // query inside the padded image
    localparam logic [1:0] OP_OOR   = 2'd2;  // query outside the padded image

    // Job queue depth
    localparam int QDEPTH = 2;

    // Effective configuration, already clamped
    typedef struct packed {
        logic [6:0]  width;
        logic [6:0]  height;
        logic [2:0]  border;
        logic [31:0] color;
    } t_cfg;

    // One job: source coordinates for writes, window center for queries
    typedef struct packed {
        logic [1:0]         op;
        logic signed [8:0]  x;
        logic signed [8:0]  y;
        logic [31:0]        data;
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/sod_ram.sv
// ----------------------------------------------------------------------------
// sod_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sod_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and read at the same address, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/sod_queue.sv
// ----------------------------------------------------------------------------
// sod_queue
// Short job queue between the front classifier and the back sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sod_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sod_pkg::t_job i_job,
    input  wire logic          i_pop,
    output sod_pkg::t_job      o_job,
    output logic               o_full,
    output logic               o_empty
);

    import sod_pkg::*;

    localparam int IW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_job          r_slot [QDEPTH];
    logic [IW-1:0] r_wr_ptr;
    logic [IW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slot[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == IW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == IW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sod_front.sv
// ----------------------------------------------------------------------------
// sod_front
// Input side: accepts items, drops writes outside the image, flags queries
// outside the padded image and turns the rest into jobs for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sod_front (
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_cmd,
    input  wire logic [6:0]    i_col,
    input  wire logic [6:0]    i_row,
    input  wire logic [31:0]   i_pixel,
    input  wire sod_pkg::t_cfg i_cfg,
    input  wire logic          i_q_full,
    output logic               o_push,
    output sod_pkg::t_job      o_job
);

    import sod_pkg::*;

    logic       wr_inside;
    logic       q_inside;
    logic [7:0] pad_w;
    logic [7:0] pad_h;

    // padded size: image plus a border on each side
    assign pad_w = {1'b0, i_cfg.width}  + {4'b0, i_cfg.border, 1'b0};
    assign pad_h = {1'b0, i_cfg.height} + {4'b0, i_cfg.border, 1'b0};

    assign wr_inside = (i_col < i_cfg.width) && (i_row < i_cfg.height);
    assign q_inside  = ({1'b0, i_col} < pad_w) && ({1'b0, i_row} < pad_h);

    assign o_ready = !i_q_full;

    // classify the item
    always_comb begin
        o_job.data = i_pixel;
        o_push     = 1'b0;
        if (i_cmd == CMD_WRITE) begin
            o_job.op = OP_WRITE;
            o_job.x  = $signed({2'b0, i_col});
            o_job.y  = $signed({2'b0, i_row});
            o_push   = i_valid && wr_inside;
        end else begin
            o_job.op = q_inside ? OP_QUERY : OP_OOR;
            // window center in source coordinates
            o_job.x  = $signed({2'b0, i_col}) - $signed({6'b0, i_cfg.border});
            o_job.y  = $signed({2'b0, i_row}) - $signed({6'b0, i_cfg.border});
            o_push   = i_valid;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sod_back.sv
// ----------------------------------------------------------------------------
// sod_back
// Job sequencer: stores pixels, checks the center pixel of a query, scans
// the window one pixel read per cycle and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sod_back #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sod_pkg::t_cfg i_cfg,
    input  wire sod_pkg::t_job i_job,
    input  wire logic          i_q_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [31:0]        o_color,
    output logic               o_in_range
);

    import sod_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CTR  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]        r_state,   n_state;
    logic signed [8:0] r_cx,      n_cx;
    logic signed [8:0] r_cy,      n_cy;
    logic signed [3:0] r_dx,      n_dx;
    logic signed [3:0] r_dy,      n_dy;
    logic              r_rd_vld,  n_rd_vld;
    logic              r_last,    n_last;
    logic [31:0]       r_res,     n_res;
    logic              r_res_rng, n_res_rng;
    logic              r_out_vld;
    logic [31:0]       r_out_color;
    logic              r_out_rng;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [31:0]       ram_rdata;
    logic signed [8:0] pos_x;
    logic signed [8:0] pos_y;
    logic signed [3:0] b_pos;
    logic signed [3:0] b_neg;
    logic              rd_opaque;
    logic              load_out;

    // store address of an in-image pixel
    function automatic logic [AW-1:0] addr_of(input logic [6:0] x, input logic [6:0] y);
        return AW'(32'(y) * 32'(MAX_WIDTH) + 32'(x));
    endfunction

    function automatic logic inside_img(input logic signed [8:0] x,
                                        input logic signed [8:0] y,
                                        input logic [6:0] w,
                                        input logic [6:0] h);
        return !x[8] && (x[7:0] < {1'b0, w}) && !y[8] && (y[7:0] < {1'b0, h});
    endfunction

    sod_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_job.data),
        .o_rdata (ram_rdata)
    );

    assign b_pos     = $signed({1'b0, i_cfg.border});
    assign b_neg     = 4'sd0 - b_pos;
    assign pos_x     = r_cx + 9'(r_dx);
    assign pos_y     = r_cy + 9'(r_dy);
    assign rd_opaque = (ram_rdata[7:0] != 8'd0);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_rd_vld  = r_rd_vld;
        n_last    = r_last;
        n_res     = r_res;
        n_res_rng = r_res_rng;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = addr_of(pos_x[6:0], pos_y[6:0]);
        load_out  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop    = 1'b1;
                    ram_addr = addr_of(i_job.x[6:0], i_job.y[6:0]);
                    unique case (i_job.op)
                        OP_WRITE: begin
                            ram_we = 1'b1;
                        end
                        OP_OOR: begin
                            n_res     = 32'd0;
                            n_res_rng = 1'b0;
                            n_state   = ST_PUSH;
                        end
                        OP_QUERY: begin
                            n_cx      = i_job.x;
                            n_cy      = i_job.y;
                            n_res_rng = 1'b1;
                            if (inside_img(i_job.x, i_job.y, i_cfg.width, i_cfg.height)) begin
                                // center read issued now, checked next cycle
                                n_state = ST_CTR;
                            end else begin
                                n_dx     = b_neg;
                                n_dy     = b_neg;
                                n_rd_vld = 1'b0;
                                n_last   = 1'b0;
                                n_state  = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CTR: begin
                if (rd_opaque) begin
                    n_res   = ram_rdata;
                    n_state = ST_PUSH;
                end else begin
                    n_dx     = b_neg;
                    n_dy     = b_neg;
                    n_rd_vld = 1'b0;
                    n_last   = 1'b0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && rd_opaque) begin
                    n_res   = i_cfg.color;
                    n_state = ST_PUSH;
                end else if (r_last) begin
                    n_res   = 32'd0;
                    n_state = ST_PUSH;
                end else begin
                    // issue a read for the current window pixel if it is in the image
                    n_rd_vld = inside_img(pos_x, pos_y, i_cfg.width, i_cfg.height);
                    if (r_dy == b_pos) begin
                        n_dy = b_neg;
                        if (r_dx == b_pos) begin
                            n_last = 1'b1;
                        end else begin
                            n_dx = r_dx + 4'sd1;
                        end
                    end else begin
                        n_dy = r_dy + 4'sd1;
                    end
                end
            end
            ST_PUSH: begin
                if (!r_out_vld || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_vld  <= 1'b0;
            r_last    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= n_rd_vld;
            r_last   <= n_last;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_res     <= n_res;
        r_res_rng <= n_res_rng;
        if (load_out) begin
            r_out_color <= r_res;
            r_out_rng   <= r_res_rng;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_color    = r_out_color;
    assign o_in_range = r_out_rng;

endmodule

`default_nettype wire

FILE: rtl/sprite_outline_dilation_unit.sv
// ----------------------------------------------------------------------------
// sprite_outline_dilation_unit
// Source pixel store with outline query: returns a pixel of the source image
// padded by a border, with transparent pixels near opaque ones outlined.
// ----------------------------------------------------------------------------
// Write items (cmd 0) store one RGBA8888 pixel; writes outside the image in
// use are dropped. Query items (cmd 1) name a pixel of the padded image and
// give one result: the source color if that pixel is opaque, the border color
// if any opaque pixel lies in the square window of radius border_width around
// it, else zero; queries outside the padded image give zero with in_range
// low. Items pass a two-entry queue to a sequencer that owns the single port
// of the pixel store. A write is stored as it is popped; an out-of-range
// query goes straight to the result; a query on an in-image pixel checks
// that pixel first and, if transparent, scans the window one store read per
// cycle, ending early at the first opaque pixel. The store is not cleared:
// query only pixels that have been written. Configuration is to be written
// while the block is idle (not enforced); out-of-range values are clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_outline_dilation_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_BORDER = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // input items
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [6:0]  i_col,
    input  wire logic [6:0]  i_row,
    input  wire logic [7:0]  i_in_red,
    input  wire logic [7:0]  i_in_green,
    input  wire logic [7:0]  i_in_blue,
    input  wire logic [7:0]  i_in_alpha,
    // result items
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_red,
    output logic [7:0]       o_out_green,
    output logic [7:0]       o_out_blue,
    output logic [7:0]       o_out_alpha,
    output logic             o_in_range
);

    import sod_pkg::*;

    localparam int W_CAP = (MAX_WIDTH  > 127) ? 127 : MAX_WIDTH;
    localparam int H_CAP = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
    localparam int B_CAP = (MAX_BORDER > 7)   ? 7   : MAX_BORDER;

    logic [6:0]  r_width;
    logic [6:0]  r_height;
    logic [2:0]  r_border;
    logic [31:0] r_color;

    t_cfg        cfg;
    t_job        f_job;
    t_job        q_job;
    logic        f_push;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    logic [31:0] res_color;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'd64;
            r_height <= 7'd64;
            r_border <= 3'd1;
            r_color  <= 32'h8000_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[6:0];
                CFG_HEIGHT: r_height <= i_cfg_data[6:0];
                CFG_BORDER: r_border <= i_cfg_data[2:0];
                CFG_COLOR:  r_color  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp to the sizes the store supports
    always_comb begin
        cfg.width  = (r_width == 7'd0) ? 7'd1 :
                     (r_width > 7'(W_CAP)) ? 7'(W_CAP) : r_width;
        cfg.height = (r_height == 7'd0) ? 7'd1 :
                     (r_height > 7'(H_CAP)) ? 7'(H_CAP) : r_height;
        cfg.border = (r_border > 3'(B_CAP)) ? 3'(B_CAP) : r_border;
        cfg.color  = r_color;
    end

    sod_front u_front (
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_cmd    (i_cmd),
        .i_col    (i_col),
        .i_row    (i_row),
        .i_pixel  ({i_in_red, i_in_green, i_in_blue, i_in_alpha}),
        .i_cfg    (cfg),
        .i_q_full (q_full),
        .o_push   (f_push),
        .o_job    (f_job)
    );

    sod_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sod_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_job      (q_job),
        .i_q_empty  (q_empty),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_color    (res_color),
        .o_in_range (o_in_range)
    );

    assign o_out_red   = res_color[31:24];
    assign o_out_green = res_color[23:16];
    assign o_out_blue  = res_color[15:8];
    assign o_out_alpha = res_color[7:0];

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sprite_outline_dilation_unit. Directed and random
// pixel writes and outline queries go in through valid/ready with random
// gaps and stalls on both sides. Several image sizes, borders and colors are
// used. A scoreboard keeps its own copy of the pixel store, predicts every
// query and checks each result in order.
// ----------------------------------------------------------------------------
module testbench;
    import sod_pkg::*;

    localparam int STORE_COLS     = 64;
    localparam int STORE_ROWS     = 64;
    localparam int DRAIN_CYCLES   = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 66;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       in_range;
    } pixel_result_t;

    // Outline predictor and in-order result checker
    class outline_scoreboard;
        logic [31:0]   pixels [STORE_COLS*STORE_ROWS];
        logic [6:0]    width_reg;
        logic [6:0]    height_reg;
        logic [2:0]    border_reg;
        logic [31:0]   color_reg;
        pixel_result_t expected_q [$];
        int            errors;

        function new();
            width_reg  = 7'd64;
            height_reg = 7'd64;
            border_reg = 3'd1;
            color_reg  = 32'h8000_0000;
            errors     = 0;
        endfunction

        // Register values as the block uses them (zero acts as 1, clamp high)
        function int eff_width();
            if (width_reg == 7'd0) return 1;
            if (int'(width_reg) > STORE_COLS) return STORE_COLS;
            return int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg == 7'd0) return 1;
            if (int'(height_reg) > STORE_ROWS) return STORE_ROWS;
            return int'(height_reg);
        endfunction

        function int eff_border();
            if (int'(border_reg) > 4) return 4;
            return int'(border_reg);
        endfunction

        function void note_config(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_WIDTH:  width_reg  = data[6:0];
                CFG_HEIGHT: height_reg = data[6:0];
                CFG_BORDER: border_reg = data[2:0];
                CFG_COLOR:  color_reg  = data;
                default: ;
            endcase
        endfunction

        function bit opaque(int x, int y);
            if (x < 0 || y < 0 || x >= eff_width() || y >= eff_height()) return 1'b0;
            return pixels[y*STORE_COLS + x][7:0] != 8'd0;
        endfunction

        // Accepted input item: store a write, or predict a query
        function void note_item(logic cmd, logic [6:0] col, logic [6:0] row,
                                logic [31:0] rgba);
            int            bw;
            int            cx;
            int            cy;
            int            dx;
            int            dy;
            bit            hit;
            logic [31:0]   color;
            pixel_result_t res;
            bw = eff_border();
            if (cmd == CMD_WRITE) begin
                if (int'(col) < eff_width() && int'(row) < eff_height())
                    pixels[int'(row)*STORE_COLS + int'(col)] = rgba;
                return;
            end
            color = 32'd0;
            res.in_range = 1'b0;
            if (int'(col) < eff_width() + 2*bw && int'(row) < eff_height() + 2*bw) begin
                res.in_range = 1'b1;
                cx = int'(col) - bw;
                cy = int'(row) - bw;
                if (opaque(cx, cy)) begin
                    color = pixels[cy*STORE_COLS + cx];
                end else begin
                    hit = 1'b0;
                    for (dy = -bw; dy <= bw; dy++)
                        for (dx = -bw; dx <= bw; dx++)
                            if (opaque(cx + dx, cy + dy)) hit = 1'b1;
                    if (hit) color = color_reg;
                end
            end
            {res.red, res.green, res.blue, res.alpha} = color;
            expected_q.push_back(res);
        endfunction

        function void check_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%t mismatch on %s: expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(pixel_result_t got);
            pixel_result_t want;
            if (expected_q.size() == 0) begin
                $display("%t unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            check_field("out_red", want.red, got.red);
            check_field("out_green", want.green, got.green);
            check_field("out_blue", want.blue, got.blue);
            check_field("out_alpha", want.alpha, got.alpha);
            check_field("in_range", 8'(want.in_range), 8'(got.in_range));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // Clock, reset and block inputs
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_WIDTH;
    logic [31:0] cfg_data  = 32'd0;
    logic        in_valid  = 1'b0;
    logic        in_cmd    = CMD_WRITE;
    logic [6:0]  in_col    = 7'd0;
    logic [6:0]  in_row    = 7'd0;
    logic [7:0]  in_red    = 8'd0;
    logic [7:0]  in_green  = 8'd0;
    logic [7:0]  in_blue   = 8'd0;
    logic [7:0]  in_alpha  = 8'd0;
    logic        out_ready = 1'b0;

    wire logic       o_ready;
    wire logic       o_valid;
    wire logic [7:0] o_out_red;
    wire logic [7:0] o_out_green;
    wire logic [7:0] o_out_blue;
    wire logic [7:0] o_out_alpha;
    wire logic       o_in_range;

    bit                no_idle = 1'b0;
    bit                written_map [STORE_COLS*STORE_ROWS];
    int                idle_cycles = 0;
    outline_scoreboard sb = new();

    initial forever #1 clk = ~clk;

    sprite_outline_dilation_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_valid     (in_valid),
        .o_ready     (o_ready),
        .i_cmd       (in_cmd),
        .i_col       (in_col),
        .i_row       (in_row),
        .i_in_red    (in_red),
        .i_in_green  (in_green),
        .i_in_blue   (in_blue),
        .i_in_alpha  (in_alpha),
        .o_valid     (o_valid),
        .i_ready     (out_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .o_in_range  (o_in_range)
    );

    // Handshake monitors: predict on input items, check on result items
    always @(posedge clk) begin
        if (rst_n && in_valid && o_ready)
            sb.note_item(in_cmd, in_col, in_row, {in_red, in_green, in_blue, in_alpha});
        if (rst_n && o_valid && out_ready)
            sb.check_result(pixel_result_t'({o_out_red, o_out_green, o_out_blue,
                                              o_out_alpha, o_in_range}));
    end

    // Watchdog on cycles with no item and no register write
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_ready) || (o_valid && out_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall before taking each result
    initial begin : result_sink
        int stall;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (o_valid !== 1'b1);
        end
    end

    // One input item after a random gap; returns at the accepting edge
    task automatic send_item(logic cmd, logic [6:0] col, logic [6:0] row, logic [31:0] rgba);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_col   <= col;
        in_row   <= row;
        {in_red, in_green, in_blue, in_alpha} <= rgba;
        do @(posedge clk); while (!o_ready);
    endtask

    task automatic write_pixel(logic [6:0] col, logic [6:0] row, logic [31:0] rgba);
        if (int'(col) < sb.eff_width() && int'(row) < sb.eff_height())
            written_map[int'(row)*STORE_COLS + int'(col)] = 1'b1;
        send_item(CMD_WRITE, col, row, rgba);
    endtask

    task automatic query_pixel(logic [6:0] col, logic [6:0] row);
        send_item(CMD_QUERY, col, row, $urandom);
    endtask

    // Drop valid, wait for every result, then let trailing writes finish
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.note_config(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [31:0] wd, logic [31:0] hd, logic [31:0] bd,
                             logic [31:0] color);
        settle();
        write_reg(CFG_WIDTH, wd);
        write_reg(CFG_HEIGHT, hd);
        write_reg(CFG_BORDER, bd);
        write_reg(CFG_COLOR, color);
    endtask

    // Random bits above the ones the register keeps
    function automatic logic [31:0] with_junk(logic [31:0] v, int keep);
        return ($urandom << keep) | v;
    endfunction

    // Random color; density is the percentage of opaque pixels
    function automatic logic [31:0] random_pixel(int density);
        logic [31:0] p;
        p = $urandom;
        if ($urandom_range(0, 99) >= density) p[7:0] = 8'd0;
        else if (p[7:0] == 8'd0) p[7:0] = 8'd1;
        return p;
    endfunction

    // Write every pixel of the image in use that was never written, so that
    // no query ever reads an unwritten store entry
    task automatic fill_image(int density);
        int r;
        int c;
        for (r = 0; r < sb.eff_height(); r++)
            for (c = 0; c < sb.eff_width(); c++)
                if (!written_map[r*STORE_COLS + c])
                    write_pixel(7'(c), 7'(r), random_pixel(density));
    endtask

    // Mixed queries and writes; mostly on and just around the padded image
    task automatic run_random(int count, int density);
        int n;
        int pick;
        int pw;
        int ph;
        fill_image(density);
        pw = sb.eff_width() + 2*sb.eff_border();
        ph = sb.eff_height() + 2*sb.eff_border();
        for (n = 0; n < count; n++) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                query_pixel(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            end else if (pick < 55) begin
                query_pixel(7'($urandom_range(0, pw)), 7'($urandom_range(0, ph)));
            end else if (pick < 92) begin
                write_pixel(7'($urandom_range(0, sb.eff_width() - 1)),
                            7'($urandom_range(0, sb.eff_height() - 1)),
                            random_pixel(density));
            end else begin
                write_pixel(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                            random_pixel(density));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : main
        int          r;
        int          c;
        logic [31:0] pix;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: 4x3 image, border 1 (padded 6x5)
        configure(32'd4, 32'd3, 32'd1, 32'hA5C3_0F96);
        for (r = 0; r < 3; r++) begin
            for (c = 0; c < 4; c++) begin
                pix = 32'd0;
                if (r == 0 && c == 0) pix = 32'hFFFF_FFFF;       // opaque, all ones
                else if (r == 0 && c == 2) pix = 32'hFFFF_FF00;  // colored but transparent
                else if (r == 2 && c == 0) pix = 32'h0000_0001;  // lowest opaque alpha
                write_pixel(7'(c), 7'(r), pix);
            end
        end
        query_pixel(7'd1, 7'd1);      // opaque source pixel
        query_pixel(7'd1, 7'd3);      // opaque with alpha 1
        query_pixel(7'd0, 7'd0);      // padding corner next to opaque: outline
        query_pixel(7'd2, 7'd2);      // transparent pixel next to opaque: outline
        query_pixel(7'd5, 7'd4);      // nothing opaque nearby: zero
        query_pixel(7'd6, 7'd0);      // first column past the padded image
        query_pixel(7'd0, 7'd5);      // first row past the padded image
        query_pixel(7'd127, 7'd127);  // far outside
        write_pixel(7'd4, 7'd0, 32'hFFFF_FFFF);      // outside image: dropped
        write_pixel(7'd0, 7'd3, 32'hFFFF_FFFF);      // outside image: dropped
        write_pixel(7'd127, 7'd127, 32'hFFFF_FFFF);  // outside image: dropped
        query_pixel(7'd4, 7'd1);      // window reaches the dropped column

        // Random phases over sizes, borders and colors, extremes included
        configure(with_junk(32'd0, 7), 32'd9, 32'd4, 32'd0);   // width 0 acts as 1
        run_random(RANDOM_ITEMS, 20);
        configure(32'd7, 32'd1, 32'd0, 32'hFFFF_FFFF);         // no border
        run_random(RANDOM_ITEMS, 40);
        configure(32'd12, 32'd10, with_junk(32'd7, 3), $urandom);  // border clamps to 4
        run_random(RANDOM_ITEMS, 30);
        configure(32'd127, 32'd6, 32'd2, $urandom);            // width clamps to 64
        run_random(RANDOM_ITEMS, 25);
        configure(32'd3, 32'd127, 32'd3, $urandom);            // height clamps to 64
        run_random(RANDOM_ITEMS, 35);
        repeat (4) begin
            configure(with_junk(32'($urandom_range(1, 16)), 7),
                      with_junk(32'($urandom_range(1, 16)), 7),
                      with_junk(32'($urandom_range(0, 7)), 3), $urandom);
            run_random(RANDOM_ITEMS, $urandom_range(5, 60));
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
